>>> rtl/core/led_pkg.sv
// Package for the line editor with history: sizes, key codes, queue entry type, sequencer states.
// No dependencies.
package led_pkg;
  localparam int LineCap = 64;
  localparam int RingDepth = 8;
  localparam int PosW = $clog2(LineCap + 1);
  localparam int IdxW = $clog2(LineCap);
  localparam int SlotW = $clog2(RingDepth);
  localparam int HistW = SlotW + IdxW;

  typedef enum logic [3:0] {
    KeyChar = 4'd0, KeyHome = 4'd1, KeyEnd = 4'd2, KeyLeft = 4'd3, KeyRight = 4'd4,
    KeyFind = 4'd5, KeySwap = 4'd6, KeyDelUnder = 4'd7, KeyDelLeft = 4'd8,
    KeyKill = 4'd9, KeyUp = 4'd10, KeyDown = 4'd11, KeyEnter = 4'd12, KeyOther = 4'd13
  } key_e;

  typedef struct packed {
    logic [3:0] key;
    logic [7:0] ch;
  } item_t;

  typedef enum logic [4:0] {
    StIdle, StDispatch, StInsRd, StInsWr, StInsPut, StDelRd, StDelWr,
    StSwapRdA, StSwapRdB, StSwapWrA, StSwapWrB, StFindRd, StFindChk,
    StLoadRd, StLoadWr, StCmpRd, StCmpChk, StEmitRd, StEmitOut, StEmitEmpty,
    StStatus
  } state_e;
endpackage

>>> rtl/core/led_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module led_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/core/led_front.sv
// Front part: accepts key events into a two-entry queue toward the back part.
// Depends on led_pkg.
module led_front import led_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [3:0] key_cmd_i,
  input  logic [7:0] char_in_i,
  output logic       q_valid_o,
  output item_t      q_item_o,
  input  logic       q_pop_i
);
  item_t      buf_q [2];
  logic       rd_q, wr_q;
  logic [1:0] cnt_q;
  logic       push;
  item_t      in_item;

  assign in_item.key = (key_cmd_i > 4'd13) ? 4'(KeyOther) : key_cmd_i;
  assign in_item.ch  = char_in_i;
  assign in_ready_o  = cnt_q != 2'd2;
  assign push        = in_valid_i && in_ready_o;
  assign q_valid_o   = cnt_q != 2'd0;
  assign q_item_o    = buf_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= in_item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0; wr_q <= 1'b0; cnt_q <= 2'd0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (q_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push) - 2'(q_pop_i);
    end
  end
endmodule

>>> rtl/core/led_back.sv
// Back part: sequencer that edits the line, searches, browses and saves history.
// Depends on led_pkg and led_ram.
module led_back import led_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  item_t            q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic             out_kind_o,
  output logic [7:0]       line_char_o,
  output logic [PosW-1:0]  cursor_pos_o,
  output logic [PosW-1:0]  line_length_o,
  output logic             line_empty_o,
  output logic             last_o
);
  state_e state_q, state_d;
  item_t  item_q;
  logic [PosW-1:0] len_q, cur_q, idx_q, end_q;
  logic [PosW-1:0] idx_m1, idx_p1, cur_m1, cur_p1;
  logic [IdxW-1:0] ln_waddr, ln_raddr;
  logic [7:0]      ln_wdata, ln_rdata;
  logic            ln_we;
  logic [HistW-1:0] h_waddr, h_raddr;
  logic [7:0]      h_rdata;
  logic            h_we;
  logic [PosW-1:0] slen_q [RingDepth];
  logic [RingDepth-1:0] sval_q;
  logic [SlotW-1:0] wslot_q, bslot_q, slot_q, prev_slot, next_wslot;
  logic [SlotW-1:0] up_base, up_slot, down_base, down_slot;
  logic            bon_q, fpend_q, ton_q, wrap_q, save_q;
  logic [7:0]      tgt_q, hold_q;
  logic            obusy_q, emit_ok, out_load;
  logic            o_kind_q, o_empty_q, o_last_q;
  logic [7:0]      o_char_q;
  logic [PosW-1:0] o_cur_q, o_len_q;
  logic            printable, find_go, dup_cand, line_last, load_last;

  led_ram #(.Width(8), .Depth(LineCap)) u_line (
    .clk_i, .we_i(ln_we), .waddr_i(ln_waddr), .wdata_i(ln_wdata),
    .raddr_i(ln_raddr), .rdata_o(ln_rdata));
  led_ram #(.Width(8), .Depth(RingDepth * LineCap)) u_hist (
    .clk_i, .we_i(h_we), .waddr_i(h_waddr), .wdata_i(ln_rdata),
    .raddr_i(h_raddr), .rdata_o(h_rdata));

  assign idx_m1     = idx_q - 1'b1;
  assign idx_p1     = idx_q + 1'b1;
  assign cur_m1     = cur_q - 1'b1;
  assign cur_p1     = cur_q + 1'b1;
  assign prev_slot  = (wslot_q == '0) ? SlotW'(RingDepth - 1) : wslot_q - 1'b1;
  assign next_wslot = (wslot_q == SlotW'(RingDepth - 1)) ? '0 : wslot_q + 1'b1;
  assign up_base    = bon_q ? bslot_q : wslot_q;
  assign up_slot    = (up_base != '0) ? up_base - 1'b1 :
                      (sval_q[RingDepth-1] ? SlotW'(RingDepth - 1) : prev_slot);
  assign down_base  = !bon_q ? wslot_q :
                      ((bslot_q == SlotW'(RingDepth - 1)) ? '0 : bslot_q + 1'b1);
  assign down_slot  = sval_q[down_base] ? down_base : '0;
  assign printable  = item_q.ch >= 8'd32 && item_q.ch <= 8'd126;
  assign find_go    = item_q.key == KeyChar || (item_q.key == KeyFind && ton_q);
  assign dup_cand   = sval_q[prev_slot] && slen_q[prev_slot] == len_q;
  assign line_last  = idx_p1 == end_q;
  assign load_last  = idx_p1 >= slen_q[slot_q];
  assign emit_ok    = !obusy_q || out_ready_i;
  assign out_load   = emit_ok && (state_q == StEmitOut || state_q == StEmitEmpty ||
                                  state_q == StStatus);

  assign out_valid_o   = obusy_q;
  assign out_kind_o    = o_kind_q;
  assign line_char_o   = o_char_q;
  assign cursor_pos_o  = o_cur_q;
  assign line_length_o = o_len_q;
  assign line_empty_o  = o_empty_q;
  assign last_o        = o_last_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle: if (q_valid_i) state_d = StDispatch;
      StDispatch: begin
        state_d = StStatus;
        if (fpend_q) begin
          if (find_go) state_d = StFindRd;
        end else begin
          unique case (item_q.key)
            KeyChar: if (printable && len_q < PosW'(LineCap)) begin
              state_d = (cur_q == len_q) ? StInsPut : StInsRd;
            end
            KeySwap:     if (cur_p1 < len_q) state_d = StSwapRdA;
            KeyDelUnder: if (cur_p1 < len_q) state_d = StDelRd;
            KeyDelLeft:  if (cur_q != '0 && cur_q < len_q) state_d = StDelRd;
            KeyUp, KeyDown: if (sval_q[0]) state_d = StLoadRd;
            KeyEnter: begin
              if (len_q == '0) state_d = StEmitEmpty;
              else if (dup_cand) state_d = StCmpRd;
              else state_d = StEmitRd;
            end
            default: ;
          endcase
        end
      end
      StInsRd:   state_d = StInsWr;
      StInsWr:   state_d = (idx_m1 == cur_q) ? StInsPut : StInsRd;
      StInsPut:  state_d = StStatus;
      StDelRd:   state_d = StDelWr;
      StDelWr:   state_d = (idx_p1 + 1'b1 == len_q) ? StStatus : StDelRd;
      StSwapRdA: state_d = StSwapRdB;
      StSwapRdB: state_d = StSwapWrA;
      StSwapWrA: state_d = StSwapWrB;
      StSwapWrB: state_d = StStatus;
      StFindRd: begin
        if (!wrap_q && idx_q >= len_q) state_d = StFindRd;
        else if (wrap_q && idx_q >= cur_q) state_d = StStatus;
        else state_d = StFindChk;
      end
      StFindChk: state_d = (ln_rdata == tgt_q) ? StStatus : StFindRd;
      StLoadRd:  state_d = StLoadWr;
      StLoadWr:  state_d = load_last ? StStatus : StLoadRd;
      StCmpRd:   state_d = StCmpChk;
      StCmpChk:  state_d = (ln_rdata != h_rdata || line_last) ? StEmitRd : StCmpRd;
      StEmitRd:  state_d = StEmitOut;
      StEmitOut: if (emit_ok) state_d = line_last ? StIdle : StEmitRd;
      StEmitEmpty, StStatus: if (emit_ok) state_d = StIdle;
      default:   state_d = StIdle;
    endcase
  end

  always_comb begin
    q_pop_o = 1'b0;
    ln_we = 1'b0; ln_waddr = idx_q[IdxW-1:0]; ln_wdata = ln_rdata;
    ln_raddr = idx_q[IdxW-1:0];
    h_we = 1'b0; h_waddr = {wslot_q, idx_q[IdxW-1:0]};
    h_raddr = {slot_q, idx_q[IdxW-1:0]};
    unique case (state_q)
      StIdle:    q_pop_o = q_valid_i;
      StInsRd:   ln_raddr = idx_m1[IdxW-1:0];
      StInsWr:   ln_we = 1'b1;
      StInsPut: begin
        ln_we = 1'b1; ln_waddr = cur_q[IdxW-1:0]; ln_wdata = item_q.ch;
      end
      StDelRd:   ln_raddr = idx_p1[IdxW-1:0];
      StDelWr:   ln_we = 1'b1;
      StSwapRdA: ln_raddr = cur_q[IdxW-1:0];
      StSwapRdB: ln_raddr = cur_p1[IdxW-1:0];
      StSwapWrA: begin
        ln_we = 1'b1; ln_waddr = cur_q[IdxW-1:0];
      end
      StSwapWrB: begin
        ln_we = 1'b1; ln_waddr = cur_p1[IdxW-1:0]; ln_wdata = hold_q;
      end
      StLoadWr: begin
        ln_we = 1'b1; ln_wdata = h_rdata;
      end
      StCmpRd:   h_raddr = {prev_slot, idx_q[IdxW-1:0]};
      StEmitOut: h_we = save_q && emit_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle; item_q <= '0; len_q <= '0; cur_q <= '0; idx_q <= '0;
      end_q <= '0; sval_q <= '0; wslot_q <= '0; bslot_q <= '0; slot_q <= '0;
      bon_q <= 1'b0; fpend_q <= 1'b0; ton_q <= 1'b0; wrap_q <= 1'b0; save_q <= 1'b0;
      tgt_q <= '0; hold_q <= '0; obusy_q <= 1'b0;
      o_kind_q <= 1'b0; o_empty_q <= 1'b0; o_last_q <= 1'b0; o_char_q <= '0;
      o_cur_q <= '0; o_len_q <= '0;
      for (int i = 0; i < RingDepth; i++) slen_q[i] <= '0;
    end else begin
      state_q <= state_d;
      obusy_q <= out_load || (obusy_q && !out_ready_i);
      unique case (state_q)
        StIdle: if (q_valid_i) item_q <= q_item_i;
        StDispatch: begin
          if (fpend_q) begin
            fpend_q <= 1'b0;
            if (item_q.key == KeyChar) begin
              ton_q <= 1'b1; tgt_q <= item_q.ch;
            end else if (item_q.key != KeyFind) ton_q <= 1'b0;
            idx_q <= cur_p1; wrap_q <= 1'b0;
          end else begin
            unique case (item_q.key)
              KeyChar:  idx_q <= len_q;
              KeyHome:  cur_q <= '0;
              KeyEnd:   cur_q <= len_q;
              KeyLeft:  if (cur_q != '0) cur_q <= cur_m1;
              KeyRight: if (cur_q < len_q) cur_q <= cur_p1;
              KeyFind:  fpend_q <= 1'b1;
              KeyDelUnder: begin
                idx_q <= cur_q;
                if (cur_p1 == len_q) len_q <= len_q - 1'b1;
              end
              KeyDelLeft: if (cur_q != '0) begin
                cur_q <= cur_m1; idx_q <= cur_m1;
                if (cur_q == len_q) len_q <= len_q - 1'b1;
              end
              KeyKill: begin
                len_q <= '0; cur_q <= '0; bon_q <= 1'b0;
              end
              KeyUp: begin
                slot_q <= up_slot; idx_q <= '0;
              end
              KeyDown: begin
                slot_q <= down_slot; idx_q <= '0;
              end
              KeyEnter: begin
                bon_q <= 1'b0; end_q <= len_q; idx_q <= '0; save_q <= 1'b1;
                len_q <= '0; cur_q <= '0;
              end
              default: ;
            endcase
          end
        end
        StInsWr:  idx_q <= idx_m1;
        StInsPut: begin
          cur_q <= cur_p1; len_q <= len_q + 1'b1;
        end
        StDelWr: begin
          idx_q <= idx_p1;
          if (idx_p1 + 1'b1 == len_q) len_q <= len_q - 1'b1;
        end
        StSwapRdB: hold_q <= ln_rdata;
        StFindRd: if (!wrap_q && idx_q >= len_q) begin
          wrap_q <= 1'b1; idx_q <= '0;
        end
        StFindChk: begin
          if (ln_rdata == tgt_q) cur_q <= idx_q;
          else idx_q <= idx_p1;
        end
        StLoadWr: begin
          idx_q <= idx_p1;
          if (load_last) begin
            len_q <= slen_q[slot_q]; cur_q <= slen_q[slot_q]; bslot_q <= slot_q;
            bon_q <= 1'b1;
          end
        end
        StCmpChk: begin
          if (ln_rdata != h_rdata) idx_q <= '0;
          else if (line_last) begin
            save_q <= 1'b0; idx_q <= '0;
          end else idx_q <= idx_p1;
        end
        StEmitOut: if (emit_ok) begin
          o_kind_q <= 1'b1; o_char_q <= ln_rdata; o_cur_q <= '0; o_len_q <= '0;
          o_empty_q <= 1'b0; o_last_q <= line_last;
          idx_q <= idx_p1;
          if (line_last && save_q) begin
            slen_q[wslot_q] <= end_q; sval_q[wslot_q] <= 1'b1; wslot_q <= next_wslot;
          end
        end
        StEmitEmpty: if (emit_ok) begin
          o_kind_q <= 1'b1; o_char_q <= '0; o_cur_q <= '0; o_len_q <= '0;
          o_empty_q <= 1'b1; o_last_q <= 1'b1;
        end
        StStatus: if (emit_ok) begin
          o_kind_q <= 1'b0; o_char_q <= '0; o_cur_q <= cur_q; o_len_q <= len_q;
          o_empty_q <= 1'b0; o_last_q <= 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

>>> rtl/core/line_editor_with_history.sv
// Top level of the line editor with history.
// Depends on led_pkg, led_front, led_back and led_ram.
//
// One key event enters on the input channel (key_cmd_i, char_in_i) when
// in_valid_i and in_ready_o are high. A front queue of two entries takes keys
// while the back sequencer works; in_ready_o drops while two keys wait.
// Each key gives one status result, except enter, which gives one result per
// character of the line (or one marked empty). Insert shifts the characters right
// of the cursor; deletes move the characters after the removed one; swap
// exchanges two characters; a search reads line positions; browsing loads
// the saved line character by character.
// Enter first compares the line with the newest saved line, character by
// character, when their lengths match, then emits the characters one by one
// while the receiver is ready, copying them into history unless the line
// matched the newest saved line. Keys are handled one at a time.
// A stalled receiver holds the result register and the sequencer waits.
// Reset clears the line, cursor, history valid bits and all handshake state;
// no clearing pass is needed.
module line_editor_with_history import led_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [3:0]      key_cmd_i,
  input  logic [7:0]      char_in_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            out_kind_o,
  output logic [7:0]      line_char_o,
  output logic [PosW-1:0] cursor_pos_o,
  output logic [PosW-1:0] line_length_o,
  output logic            line_empty_o,
  output logic            last_o
);
  logic  q_valid, q_pop;
  item_t q_item;

  led_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .key_cmd_i, .char_in_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop));

  led_back u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_ready_i, .out_kind_o, .line_char_o, .cursor_pos_o,
    .line_length_o, .line_empty_o, .last_o);
endmodule

>>> dv/led_checker.sv
// Checker for the line editor with history: watches both channels, predicts the results
// of every accepted key and compares all fields of each result. Depends on led_pkg.
module led_checker import led_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_ready_i,
  input  logic [3:0]      key_cmd_i,
  input  logic [7:0]      char_in_i,
  input  logic            out_valid_i,
  input  logic            out_ready_i,
  input  logic            out_kind_i,
  input  logic [7:0]      line_char_i,
  input  logic [PosW-1:0] cursor_pos_i,
  input  logic [PosW-1:0] line_length_i,
  input  logic            line_empty_i,
  input  logic            last_i,
  output int              fail_count_o,
  output int              pending_o,
  output int              result_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic            kind;
    logic [7:0]      ch;
    logic [PosW-1:0] cur;
    logic [PosW-1:0] len;
    logic            empty;
    logic            last;
  } edit_result_t;

  edit_result_t expected_q[$];

  logic [7:0] line_buf[LineCap];
  int         line_len;
  int         cur;
  logic [7:0] hist_line[RingDepth][LineCap];
  int         hist_len[RingDepth];
  bit         hist_valid[RingDepth];
  int         write_slot;
  int         browse_slot;
  bit         browsing;
  bit         find_armed;
  bit         target_set;
  logic [7:0] target;

  function automatic void push_result(logic kind, logic [7:0] ch, logic empty, logic last);
    edit_result_t r;
    r.kind = kind;
    r.ch = ch;
    r.cur = (kind && !empty) || (kind && empty) ? '0 : cur[PosW-1:0];
    r.len = kind ? '0 : line_len[PosW-1:0];
    r.empty = empty;
    r.last = last;
    expected_q.push_back(r);
  endfunction

  function automatic void remove_under_cursor();
    if (cur >= line_len) return;
    for (int i = cur; i + 1 < line_len; i++) line_buf[i] = line_buf[i + 1];
    line_len--;
  endfunction

  function automatic void jump_to_target();
    if (!target_set) return;
    for (int i = cur + 1; i < line_len; i++) begin
      if (line_buf[i] == target) begin
        cur = i;
        return;
      end
    end
    for (int i = 0; i < cur; i++) begin
      if (line_buf[i] == target) begin
        cur = i;
        return;
      end
    end
  endfunction

  function automatic void recall_slot(int s);
    for (int i = 0; i < hist_len[s]; i++) line_buf[i] = hist_line[s][i];
    line_len = hist_len[s];
    cur = line_len;
    browse_slot = s;
    browsing = 1'b1;
  endfunction

  function automatic void store_in_history();
    int prev;
    bit same;
    if (line_len == 0) return;
    prev = (write_slot + RingDepth - 1) % RingDepth;
    same = hist_valid[prev] && hist_len[prev] == line_len;
    for (int i = 0; same && i < line_len; i++) same = hist_line[prev][i] == line_buf[i];
    if (same) return;
    for (int i = 0; i < line_len; i++) hist_line[write_slot][i] = line_buf[i];
    hist_len[write_slot] = line_len;
    hist_valid[write_slot] = 1'b1;
    write_slot = (write_slot + 1) % RingDepth;
  endfunction

  function automatic void predict_key(logic [3:0] key, logic [7:0] ch);
    int t;
    int n;
    logic [7:0] tmp;
    if (find_armed) begin
      find_armed = 1'b0;
      if (key == KeyChar) begin
        target_set = 1'b1;
        target = ch;
      end else if (key != KeyFind) begin
        target_set = 1'b0;
      end
      jump_to_target();
      push_result(1'b0, '0, 1'b0, 1'b1);
      return;
    end
    case (key)
      KeyChar: begin
        if (ch >= 8'd32 && ch <= 8'd126 && line_len < LineCap) begin
          for (int i = line_len; i > cur; i--) line_buf[i] = line_buf[i - 1];
          line_buf[cur] = ch;
          cur++;
          line_len++;
        end
      end
      KeyHome: cur = 0;
      KeyEnd: cur = line_len;
      KeyLeft: if (cur > 0) cur--;
      KeyRight: if (cur < line_len) cur++;
      KeyFind: find_armed = 1'b1;
      KeySwap: begin
        if (cur + 1 < line_len) begin
          tmp = line_buf[cur];
          line_buf[cur] = line_buf[cur + 1];
          line_buf[cur + 1] = tmp;
        end
      end
      KeyDelUnder: remove_under_cursor();
      KeyDelLeft: begin
        if (cur > 0) begin
          cur--;
          remove_under_cursor();
        end
      end
      KeyKill: begin
        line_len = 0;
        cur = 0;
        browsing = 1'b0;
      end
      KeyUp: begin
        if (hist_valid[0]) begin
          t = browsing ? browse_slot : write_slot;
          if (t == 0) begin
            t = RingDepth - 1;
            if (!hist_valid[t]) t = (write_slot + RingDepth - 1) % RingDepth;
          end else begin
            t--;
          end
          recall_slot(t);
        end
      end
      KeyDown: begin
        if (hist_valid[0]) begin
          t = browsing ? browse_slot + 1 : write_slot;
          if (t >= RingDepth) t = 0;
          if (!hist_valid[t]) t = 0;
          recall_slot(t);
        end
      end
      KeyEnter: begin
        n = line_len;
        store_in_history();
        browsing = 1'b0;
        line_len = 0;
        cur = 0;
        if (n == 0) begin
          push_result(1'b1, '0, 1'b1, 1'b1);
        end else begin
          for (int i = 0; i < n; i++) push_result(1'b1, line_buf[i], 1'b0, i + 1 == n);
        end
        return;
      end
      default: ;
    endcase
    push_result(1'b0, '0, 1'b0, 1'b1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    edit_result_t got;
    edit_result_t want;
    if (!rst_ni) begin
      expected_q.delete();
      line_len = 0;
      cur = 0;
      write_slot = 0;
      browse_slot = 0;
      browsing = 1'b0;
      find_armed = 1'b0;
      target_set = 1'b0;
      target = '0;
      for (int s = 0; s < RingDepth; s++) begin
        hist_valid[s] = 1'b0;
        hist_len[s] = 0;
      end
      fail_count_o = 0;
      result_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{out_kind_i, line_char_i, cursor_pos_i, line_length_i, line_empty_i, last_i};
        result_count_o++;
        if (expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10) $display("%0t: unexpected result %p", $time, got);
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            fail_count_o++;
            if (fail_count_o <= 10) begin
              $display("%0t: result mismatch, expected %p, got %p", $time, want, got);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) predict_key(key_cmd_i, char_in_i);
    end
    pending_o = expected_q.size();
  end
endmodule

>>> dv/line_editor_with_history_tb.sv
// Testbench top for the line editor with history: drives directed and random key requests with random gaps
// and receiver stalls, and gives the verdict. Depends on led_pkg, led_checker and line_editor_with_history.
module line_editor_with_history_tb;
  import led_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NumKeys = 220;
  localparam int StallLimit = 20000;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_ready_o;
  logic [3:0]      key_cmd_i = KeyOther;
  logic [7:0]      char_in_i = '0;
  logic            out_valid_o;
  logic            out_ready_i = 1'b0;
  logic            out_kind_o;
  logic [7:0]      line_char_o;
  logic [PosW-1:0] cursor_pos_o;
  logic [PosW-1:0] line_length_o;
  logic            line_empty_o;
  logic            last_o;
  int              fail_count;
  int              pending;
  int              result_count;
  int              keys_sent = 0;
  int              send_idle_pct = 0;
  int              stall_pct = 0;
  int              quiet_cycles = 0;

  always #5 clk_i = ~clk_i;

  line_editor_with_history i_dut (.*);

  led_checker i_checker (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .key_cmd_i, .char_in_i,
    .out_valid_i(out_valid_o), .out_ready_i, .out_kind_i(out_kind_o),
    .line_char_i(line_char_o), .cursor_pos_i(cursor_pos_o),
    .line_length_i(line_length_o), .line_empty_i(line_empty_o), .last_i(last_o),
    .fail_count_o(fail_count), .pending_o(pending), .result_count_o(result_count)
  );

  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic send_key(logic [3:0] key, logic [7:0] ch);
    in_valid_i <= 1'b1;
    key_cmd_i <= key;
    char_in_i <= ch;
    do @(negedge clk_i); while (!in_ready_o);
    @(posedge clk_i);
    keys_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  function automatic logic [7:0] pick_char();
    return ($urandom_range(1) != 0) ? 8'($urandom_range(97, 100)) : 8'($urandom_range(32, 126));
  endfunction

  task automatic send_random_sequence();
    int r;
    r = $urandom_range(99);
    if (r < 3) begin
      repeat ($urandom_range(60, 70)) send_key(KeyChar, pick_char());
    end else if (r < 30) begin
      repeat ($urandom_range(1, 8)) send_key(KeyChar, pick_char());
    end else if (r < 45) begin
      case ($urandom_range(6))
        0: send_key(KeyHome, 8'($urandom));
        1: send_key(KeyEnd, 8'($urandom));
        2: send_key(KeyLeft, 8'($urandom));
        3: send_key(KeyRight, 8'($urandom));
        4: send_key(KeySwap, 8'($urandom));
        5: send_key(KeyDelUnder, 8'($urandom));
        default: send_key(KeyDelLeft, 8'($urandom));
      endcase
    end else if (r < 55) begin
      send_key(KeyFind, 8'($urandom));
      case ($urandom_range(3))
        0: send_key(KeyFind, 8'($urandom));
        1: send_key(4'($urandom_range(1, 15)), 8'($urandom));
        default: send_key(KeyChar, pick_char());
      endcase
    end else if (r < 70) begin
      if ($urandom_range(2) == 0) send_key(KeyUp, 8'($urandom));
      send_key(KeyEnter, 8'($urandom));
    end else if (r < 80) begin
      send_key($urandom_range(1) ? KeyUp : KeyDown, 8'($urandom));
    end else if (r < 85) begin
      send_key(KeyKill, 8'($urandom));
    end else begin
      send_key(4'($urandom), 8'($urandom));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_key(KeyUp, 8'd0);
    send_key(KeyDown, 8'd0);
    send_key(KeyEnter, 8'd0);
    send_key(KeyDelUnder, 8'd0);
    send_key(KeyDelLeft, 8'd0);
    send_key(KeyChar, 8'd31);
    send_key(KeyChar, 8'd127);
    send_key(KeyChar, 8'd255);
    send_key(KeyChar, 8'd0);
    send_key(KeyChar, 8'd32);
    send_key(KeyChar, 8'd126);
    send_key(KeyChar, "a");
    send_key(KeySwap, 8'd0);
    send_key(KeyHome, 8'd0);
    send_key(KeySwap, 8'd0);
    send_key(KeyFind, 8'd0);
    send_key(KeyChar, "a");
    send_key(KeyFind, 8'd0);
    send_key(KeyFind, 8'd0);
    send_key(KeyFind, 8'd0);
    send_key(KeyLeft, 8'd0);
    send_key(KeyRight, 8'd0);
    send_key(KeyEnd, 8'd0);
    send_key(4'd14, 8'd0);
    send_key(4'd15, 8'd0);
    send_key(KeyOther, 8'd0);
    send_key(KeyEnter, 8'd0);
    send_key(KeyUp, 8'd0);
    send_key(KeyEnter, 8'd0);
    send_key(KeyKill, 8'd0);

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? 77 : (phase == 3 ? 26 : 0);
      stall_pct = (phase == 2) ? 77 : 0;
      if (phase == 3) begin
        send_idle_pct = 26;
        stall_pct = 26;
      end
      while (keys_sent < 30 + (phase + 1) * (NumKeys - 30) / 4) send_random_sequence();
      drain_results();
    end
    send_key(KeyEnter, 8'd0);
    drain_results();

    in_valid_i <= 1'b0;
    repeat (300) @(posedge clk_i);
    $display("Run covered %0d key requests and %0d results over four idle/stall phases.",
             keys_sent, result_count);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

>>> line_editor_with_history.f
rtl/core/led_pkg.sv
rtl/core/led_ram.sv
rtl/core/led_front.sv
rtl/core/led_back.sv
rtl/core/line_editor_with_history.sv
dv/led_checker.sv
dv/line_editor_with_history_tb.sv
